// ===== hdl/fcrc_pkg.sv =====
package fcrc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CRC_INITIAL_VALUE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_FINAL_XOR     = 2'd1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic        crc_match;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        short_frame;
  } result_word_t;

  typedef struct packed {
    logic [15:0] crc_initial_value;
    logic [15:0] crc_final_xor;
  } crc_cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] b);
    logic [15:0] r;
    r = rem ^ {b, 8'h00};
    for (int i = 0; i < BYTE_BITS; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/fcrc_cfg.sv =====
module fcrc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [fcrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                        cfg_data,
  output fcrc_pkg::crc_cfg_t                 cfg
);
  import fcrc_pkg::*;

  crc_cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CRC_INITIAL_VALUE: regs.crc_initial_value <= cfg_data;
        REG_CRC_FINAL_XOR:     regs.crc_final_xor     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/fcrc_track.sv =====
module fcrc_track (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  fcrc_pkg::byte_word_t   word,
  input  fcrc_pkg::crc_cfg_t     cfg,
  output fcrc_pkg::result_word_t result
);
  import fcrc_pkg::*;

  logic [15:0] remainder;
  logic [15:0] remainder_next;
  logic [7:0]  held_old;
  logic [7:0]  held_new;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic [15:0] computed;
  logic [15:0] received;

  always_comb begin
    if (count == 2'd0) begin
      remainder_next = cfg.crc_initial_value;
    end else if (count == 2'd2) begin
      remainder_next = crc_byte(remainder, held_old);
    end else begin
      remainder_next = remainder;
    end
    count_next = (count == 2'd2) ? count : count + 2'd1;
  end

  assign computed = remainder_next ^ cfg.crc_final_xor;
  assign received = {held_new, word.frame_byte};

  always_comb begin
    if (count == 2'd0) begin
      result = '{crc_match: 1'b0, computed_crc: 16'h0000,
                 received_crc: 16'h0000, short_frame: 1'b1};
    end else begin
      result = '{crc_match: (computed == received), computed_crc: computed,
                 received_crc: received, short_frame: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (advance) begin
      count <= word.last_byte ? 2'd0 : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      remainder <= remainder_next;
      held_old  <= held_new;
      held_new  <= word.frame_byte;
    end
  end

endmodule

// ===== hdl/frame_crc16_checker.sv =====
// Path: a byte is taken into the input register; a final byte's result is then registered
// in the result register, and the final byte waits in the input register while that slot is held.
// Throughput: one byte per cycle unless a final byte waits on a stalled result; the CRC step is combinational.
// Reset (rst, synchronous): clears the input register's full flag, the frame position, the result slot and the config.
module frame_crc16_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  fcrc_pkg::byte_word_t                byte_data,
  output logic                                result_valid,
  input  logic                                result_stall,
  output fcrc_pkg::result_word_t              result_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                         cfg_data
);
  import fcrc_pkg::*;

  crc_cfg_t     cfg;
  byte_word_t   in_word;
  logic         in_full;
  logic         accept;
  logic         out_free;
  logic         advance;
  result_word_t result;

  assign cfg_ready = 1'b1;

  fcrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fcrc_track u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (in_word),
    .cfg     (cfg),
    .result  (result)
  );

  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_full && (!in_word.last_byte || out_free);
  assign byte_stall = in_full && !advance;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && in_word.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_word.last_byte) begin
      result_data <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> in_full)
    else $error("input stalled with an empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(advance && in_word.last_byte))
    else $error("result overwritten while stalled");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && result_valid && !$past(result_valid)) |->
      $past(advance && in_word.last_byte))
    else $error("result raised without a final word");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!result_valid && !in_full))
    else $error("state not cleared by reset");

endmodule

// ===== verif/frame_crc16_checker_test.sv =====
module frame_crc16_checker_test;
  import fcrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_PAD = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int RANDOM_PHASES = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {TRAILER_GOOD, TRAILER_RANDOM, TRAILER_FLIPPED} trailer_kind_t;

  typedef struct packed {
    byte_word_t   w;
    logic         typed_ok;
    result_word_t typed;
  } stim_row_t;

  localparam result_word_t NO_RES = '0;
  localparam result_word_t SHORT_RES = '{crc_match: 1'b0, computed_crc: 16'h0000,
                                         received_crc: 16'h0000, short_frame: 1'b1};
  localparam result_word_t ZERO_PAIR_RES = '{crc_match: 1'b1, computed_crc: 16'h0000,
                                             received_crc: 16'h0000, short_frame: 1'b0};
  localparam result_word_t ONES_PAIR_RES = '{crc_match: 1'b0, computed_crc: 16'h0000,
                                             received_crc: 16'hFFFF, short_frame: 1'b0};
  localparam result_word_t CHECK_RES = '{crc_match: 1'b1, computed_crc: 16'hFEE8,
                                         received_crc: 16'hFEE8, short_frame: 1'b0};

  localparam stim_row_t DIRECTED [23] = '{
    {8'h00, 1'b1, 1'b1, SHORT_RES},
    {8'hFF, 1'b1, 1'b1, SHORT_RES},
    {8'h00, 1'b0, 1'b0, NO_RES},
    {8'h00, 1'b1, 1'b1, ZERO_PAIR_RES},
    {8'hFF, 1'b0, 1'b0, NO_RES},
    {8'hFF, 1'b1, 1'b1, ONES_PAIR_RES},
    {8'h00, 1'b0, 1'b0, NO_RES},
    {8'h12, 1'b0, 1'b0, NO_RES},
    {8'h34, 1'b1, 1'b0, NO_RES},
    {8'hFF, 1'b0, 1'b0, NO_RES},
    {8'h80, 1'b0, 1'b0, NO_RES},
    {8'h01, 1'b1, 1'b0, NO_RES},
    {8'h31, 1'b0, 1'b0, NO_RES},
    {8'h32, 1'b0, 1'b0, NO_RES},
    {8'h33, 1'b0, 1'b0, NO_RES},
    {8'h34, 1'b0, 1'b0, NO_RES},
    {8'h35, 1'b0, 1'b0, NO_RES},
    {8'h36, 1'b0, 1'b0, NO_RES},
    {8'h37, 1'b0, 1'b0, NO_RES},
    {8'h38, 1'b0, 1'b0, NO_RES},
    {8'h39, 1'b0, 1'b0, NO_RES},
    {8'hFE, 1'b0, 1'b0, NO_RES},
    {8'hE8, 1'b1, 1'b1, CHECK_RES}
  };

  logic         clk;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_word_t   byte_data = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_data;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  frame_crc16_checker dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  result_word_t expected_crc_words [$];
  int           bad_results = 0;
  int           idle_cycles = 0;
  bit           hold_off_req = 1'b0;
  int           burst_left = 0;
  bit           gaps_on = 1'b1;

  logic [15:0]  init_copy = 16'h0000;
  logic [15:0]  xor_copy = 16'h0000;
  logic [15:0]  remainder_copy = 16'h0000;
  logic [7:0]   held_copy [2] = '{8'h00, 8'h00};
  int           held_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] rem, input logic [7:0] b);
    logic [15:0] r;
    r = rem;
    for (int k = 7; k >= 0; k--) begin
      r = (r[15] ^ b[k]) ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic bit predict_frame_word(input byte_word_t w, output result_word_t r);
    r = '0;
    if (held_count == 0) remainder_copy = init_copy;
    if (held_count >= 2) remainder_copy = crc16_step(remainder_copy, held_copy[0]);
    held_copy[0] = held_copy[1];
    held_copy[1] = w.frame_byte;
    if (held_count < 2) held_count++;
    if (!w.last_byte) return 1'b0;
    if (held_count < 2) begin
      r.short_frame = 1'b1;
    end else begin
      r.computed_crc = remainder_copy ^ xor_copy;
      r.received_crc = {held_copy[0], held_copy[1]};
      r.crc_match    = (r.computed_crc == r.received_crc);
    end
    held_copy[0] = 8'h00;
    held_copy[1] = 8'h00;
    held_count = 0;
    return 1'b1;
  endfunction

  task automatic send_word(input byte_word_t w, input logic typed_ok, input result_word_t typed);
    result_word_t r;
    int gap;
    byte_valid <= 1'b1;
    byte_data  <= w;
    do @(posedge clk); while (!(byte_valid && !byte_stall));
    if (predict_frame_word(w, r)) expected_crc_words.push_back(typed_ok ? typed : r);
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 40);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input int len, input trailer_kind_t kind);
    logic [7:0]  body [$];
    logic [15:0] trailer;
    byte_word_t  w;
    if (len < 2) begin
      w.frame_byte = 8'($urandom);
      w.last_byte  = 1'b1;
      send_word(w, 1'b0, NO_RES);
    end else begin
      for (int i = 0; i < len - 2; i++) body.push_back(8'($urandom));
      trailer = init_copy;
      foreach (body[i]) trailer = crc16_step(trailer, body[i]);
      trailer ^= xor_copy;
      case (kind)
        TRAILER_RANDOM:  trailer = 16'($urandom);
        TRAILER_FLIPPED: trailer ^= 16'h0001 << $urandom_range(0, 15);
        default: ;
      endcase
      body.push_back(trailer[15:8]);
      body.push_back(trailer[7:0]);
      foreach (body[i]) begin
        w.frame_byte = body[i];
        w.last_byte  = (i == body.size() - 1);
        send_word(w, 1'b0, NO_RES);
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_CRC_INITIAL_VALUE: init_copy = value;
      REG_CRC_FINAL_XOR:     xor_copy = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_crc_words.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_crc_regs(input logic [15:0] init_value, input logic [15:0] xor_value);
    byte_valid <= 1'b0;
    wait_drained();
    cfg_write(REG_CRC_INITIAL_VALUE, init_value);
    cfg_write(REG_CRC_FINAL_XOR, xor_value);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // receiver: stall on a pattern whose mode is redrawn after each random span, or hold stall during a hold-off
  initial begin
    int mode;
    int span;
    int hold_left;
    int tick;
    mode = 0;
    span = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 128);
      end
      span--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (mode)
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 9) < 6);
          3:       result_stall <= (tick % 3 == 0);
          default: result_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_crc_words.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result word: match=%0d comp=%h recv=%h short=%0d",
                   result_data.crc_match, result_data.computed_crc,
                   result_data.received_crc, result_data.short_frame);
        bad_results++;
      end else begin
        want = expected_crc_words.pop_front();
        if (result_data.crc_match !== want.crc_match ||
            result_data.computed_crc !== want.computed_crc ||
            result_data.received_crc !== want.received_crc ||
            result_data.short_frame !== want.short_frame) begin
          if (bad_results < 10)
            $display({"result mismatch: exp match=%0d comp=%h recv=%h short=%0d, ",
                      "got match=%0d comp=%h recv=%h short=%0d"},
                     want.crc_match, want.computed_crc, want.received_crc,
                     want.short_frame,
                     result_data.crc_match, result_data.computed_crc,
                     result_data.received_crc, result_data.short_frame);
          bad_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int len;
    int pick;
    bit hold_done;
    trailer_kind_t kind;
    hold_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_word(DIRECTED[i].w, DIRECTED[i].typed_ok, DIRECTED[i].typed);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       set_crc_regs(16'hFFFF, 16'hFFFF);
        1:       set_crc_regs(16'hFFFF, 16'h0000);
        2:       set_crc_regs(16'h0000, 16'hFFFF);
        3:       set_crc_regs(16'h0000, 16'h0000);
        default: set_crc_regs(16'($urandom), 16'($urandom));
      endcase
      gaps_on = (ph != 2) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // hold the receiver off so the pipeline backs up into the sender
        if (ph == 2 && !hold_done && sent >= 40) begin
          hold_off_req = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) len = 1;
        else if (pick < 12) len = 2;
        else if (pick < 90) len = $urandom_range(3, 12);
        else len = $urandom_range(13, 40);
        pick = $urandom_range(0, 9);
        kind = (pick < 6) ? TRAILER_GOOD : (pick < 8) ? TRAILER_RANDOM : TRAILER_FLIPPED;
        send_frame(len, kind);
        sent += len;
      end
    end

    byte_valid <= 1'b0;
    wait_drained();
    if (bad_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
